>>> sv/dq_pkg.sv
package dq_pkg;

    // Field widths of one request and one result item.
    localparam int FUNC_W = 3;
    localparam int DATA_W = 32;
    localparam int STAT_W = 2;
    localparam int LEN_W  = 5;

    // Request codes.
    localparam logic [FUNC_W-1:0] FUNC_PUSH_BACK  = 3'd0;
    localparam logic [FUNC_W-1:0] FUNC_PUSH_FRONT = 3'd1;
    localparam logic [FUNC_W-1:0] FUNC_POP_FRONT  = 3'd2;
    localparam logic [FUNC_W-1:0] FUNC_POP_BACK   = 3'd3;
    localparam logic [FUNC_W-1:0] FUNC_CLEAR      = 3'd4;

    // Status codes.
    localparam logic [STAT_W-1:0] ST_OK    = 2'd0;
    localparam logic [STAT_W-1:0] ST_FULL  = 2'd1;
    localparam logic [STAT_W-1:0] ST_EMPTY = 2'd2;

    typedef struct packed {
        logic [FUNC_W-1:0] func;
        logic [DATA_W-1:0] data_in;
    } req_t;

    typedef struct packed {
        logic [DATA_W-1:0] data_out;
        logic [STAT_W-1:0] status;
        logic [LEN_W-1:0]  length;
    } rsp_t;

    // Outcome of one request as decided by the pointer control.
    typedef struct packed {
        logic              pop_ok;
        logic [STAT_W-1:0] status;
        logic [LEN_W-1:0]  length;
    } dq_info_t;

endpackage

>>> sv/double_ended_queue.sv
// Latency: the result of a request is shown, with done high, in the cycle after it is accepted.
// Throughput: one request per cycle; busy never rises, since head, count and the single
// storage access of a request all complete at the edge that accepts it.
// Reset clears the head position and the word count, so the queue starts empty; the storage
// contents are not cleared. The receiver cannot stall; each result is held for one cycle only.
module double_ended_queue
    import dq_pkg::*;
#(
    parameter int DEPTH = 16
) (
    input  logic clk,
    input  logic rst_n,
    input  logic start,
    output logic busy,
    input  req_t request,
    output logic done,
    output rsp_t result
);

    localparam int PTR_W = $clog2(DEPTH);

    logic             accept;
    logic             wr_en;
    logic [PTR_W-1:0] wr_addr;
    logic [PTR_W-1:0] rd_addr;
    logic [DATA_W-1:0] rd_data;
    dq_info_t         info;

    // Result registers. The popped word itself comes from the storage
    // read register, which is loaded at the same edge as these.
    logic             done_reg;
    logic             pop_ok_reg;
    logic [STAT_W-1:0] status_reg;
    logic [LEN_W-1:0] length_reg;

    // Every request finishes its storage access at the accepting edge, so a
    // new request can always be taken.
    assign busy   = 1'b0;
    assign accept = start & ~busy;

    // Head and count bookkeeping; it picks the storage entry each request touches.
    dq_ptr_ctrl #(
        .DEPTH (DEPTH)
    ) u_ptr_ctrl (
        .clk     (clk),
        .rst_n   (rst_n),
        .accept  (accept),
        .func    (request.func),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .rd_addr (rd_addr),
        .info    (info)
    );

    // Word storage. A push writes at the accepting edge and a pop reads at it,
    // so a pop right after a push of the same entry sees the new word.
    dq_ram #(
        .WIDTH (DATA_W),
        .DEPTH (DEPTH)
    ) u_ram (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (request.data_in),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= accept;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            pop_ok_reg <= info.pop_ok;
            status_reg <= info.status;
            length_reg <= info.length;
        end
    end

    assign done            = done_reg;
    assign result.data_out = pop_ok_reg ? rd_data : '0;
    assign result.status   = status_reg;
    assign result.length   = length_reg;

endmodule

>>> sv/dq_ram.sv
module dq_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             wr_en,
    input  logic [AW-1:0]    wr_addr,
    input  logic [WIDTH-1:0] wr_data,
    input  logic [AW-1:0]    rd_addr,
    output logic [WIDTH-1:0] rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data <= mem[rd_addr];
    end

endmodule

>>> sv/dq_ptr_ctrl.sv
module dq_ptr_ctrl
    import dq_pkg::*;
#(
    parameter int DEPTH = 16,
    localparam int PTR_W = $clog2(DEPTH),
    localparam int CNT_W = $clog2(DEPTH + 1)
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             accept,
    input  logic [FUNC_W-1:0] func,
    output logic             wr_en,
    output logic [PTR_W-1:0] wr_addr,
    output logic [PTR_W-1:0] rd_addr,
    output dq_info_t         info
);

    localparam logic [PTR_W-1:0] LAST_POS = PTR_W'(DEPTH - 1);
    localparam logic [PTR_W:0]   DEPTH_EXT = (PTR_W + 1)'(DEPTH);

    logic [PTR_W-1:0] head_reg;
    logic [PTR_W-1:0] head_next;
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;

    logic             full;
    logic             empty;
    logic [CNT_W-1:0] count_m1;
    logic [PTR_W:0]   back_sum;
    logic [PTR_W:0]   last_sum;
    logic [PTR_W-1:0] back_pos;
    logic [PTR_W-1:0] last_pos;
    logic [PTR_W-1:0] head_inc;
    logic [PTR_W-1:0] head_dec;

    assign full     = (count_reg == CNT_W'(DEPTH));
    assign empty    = (count_reg == '0);
    assign count_m1 = count_reg - CNT_W'(1);

    // Both offsets stay below DEPTH, so one conditional subtract wraps them.
    assign back_sum = {1'b0, head_reg} + {1'b0, count_reg[PTR_W-1:0]};
    assign last_sum = {1'b0, head_reg} + {1'b0, count_m1[PTR_W-1:0]};
    assign back_pos = (back_sum >= DEPTH_EXT) ? PTR_W'(back_sum - DEPTH_EXT)
                                              : back_sum[PTR_W-1:0];
    assign last_pos = (last_sum >= DEPTH_EXT) ? PTR_W'(last_sum - DEPTH_EXT)
                                              : last_sum[PTR_W-1:0];
    assign head_inc = (head_reg == LAST_POS) ? '0 : head_reg + PTR_W'(1);
    assign head_dec = (head_reg == '0) ? LAST_POS : head_reg - PTR_W'(1);

    always_comb
    begin
        head_next   = head_reg;
        count_next  = count_reg;
        wr_en       = 1'b0;
        wr_addr     = back_pos;
        rd_addr     = head_reg;
        info.pop_ok = 1'b0;
        info.status = ST_OK;
        if (accept)
        begin
            unique case (func)
                FUNC_PUSH_BACK:
                begin
                    if (full)
                    begin
                        info.status = ST_FULL;
                    end
                    else
                    begin
                        wr_en      = 1'b1;
                        wr_addr    = back_pos;
                        count_next = count_reg + CNT_W'(1);
                    end
                end
                FUNC_PUSH_FRONT:
                begin
                    if (full)
                    begin
                        info.status = ST_FULL;
                    end
                    else
                    begin
                        wr_en      = 1'b1;
                        wr_addr    = head_dec;
                        head_next  = head_dec;
                        count_next = count_reg + CNT_W'(1);
                    end
                end
                FUNC_POP_FRONT:
                begin
                    if (empty)
                    begin
                        info.status = ST_EMPTY;
                    end
                    else
                    begin
                        info.pop_ok = 1'b1;
                        rd_addr     = head_reg;
                        head_next   = head_inc;
                        count_next  = count_m1;
                    end
                end
                FUNC_POP_BACK:
                begin
                    if (empty)
                    begin
                        info.status = ST_EMPTY;
                    end
                    else
                    begin
                        info.pop_ok = 1'b1;
                        rd_addr     = last_pos;
                        count_next  = count_m1;
                    end
                end
                FUNC_CLEAR:
                begin
                    head_next  = '0;
                    count_next = '0;
                end
                default:
                begin
                end
            endcase
        end
        info.length = LEN_W'(count_next);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg  <= '0;
            count_reg <= '0;
        end
        else
        begin
            head_reg  <= head_next;
            count_reg <= count_next;
        end
    end

endmodule

>>> test/dq_checker.sv
`timescale 1ns / 1ps

module dq_checker
    import dq_pkg::*;
#(
    parameter int QDEPTH = 16
) (
    input  logic clk,
    input  logic rst_n,
    input  logic start,
    input  logic busy,
    input  req_t request,
    input  logic done,
    input  rsp_t result,
    output int   errors,
    output int   outstanding
);

    localparam int IDX_W = $clog2(QDEPTH);

    // Shadow copy of the queue contents and pointers.
    logic [DATA_W-1:0] words [QDEPTH];
    logic [IDX_W-1:0]  head;
    logic [LEN_W-1:0]  fill;

    rsp_t awaited_results [$];
    int   results_seen;

    // Applies one request to the shadow queue and returns the result it must produce.
    function automatic rsp_t apply_request(input req_t item);
        rsp_t             rsp;
        logic [IDX_W-1:0] slot;
        rsp        = '0;
        rsp.status = ST_OK;
        case (item.func)
            FUNC_PUSH_BACK:
            begin
                if (fill == QDEPTH)
                    rsp.status = ST_FULL;
                else
                begin
                    slot        = head + fill[IDX_W-1:0];
                    words[slot] = item.data_in;
                    fill        = fill + 1'b1;
                end
            end
            FUNC_PUSH_FRONT:
            begin
                if (fill == QDEPTH)
                    rsp.status = ST_FULL;
                else
                begin
                    head        = head - 1'b1;
                    words[head] = item.data_in;
                    fill        = fill + 1'b1;
                end
            end
            FUNC_POP_FRONT:
            begin
                if (fill == 0)
                    rsp.status = ST_EMPTY;
                else
                begin
                    rsp.data_out = words[head];
                    head         = head + 1'b1;
                    fill         = fill - 1'b1;
                end
            end
            FUNC_POP_BACK:
            begin
                if (fill == 0)
                    rsp.status = ST_EMPTY;
                else
                begin
                    slot         = head + fill[IDX_W-1:0] - 1'b1;
                    rsp.data_out = words[slot];
                    fill         = fill - 1'b1;
                end
            end
            FUNC_CLEAR:
            begin
                head = '0;
                fill = '0;
            end
            default:
            begin
            end
        endcase
        rsp.length = fill;
        return rsp;
    endfunction

    task automatic report_mismatch(input string what, input logic [DATA_W-1:0] got,
                                   input logic [DATA_W-1:0] want);
        errors++;
        $display("[%0t] result %0d: %s is 0x%0h, expected 0x%0h",
                 $time, results_seen, what, got, want);
    endtask

    // Results are checked before the item accepted at the same edge is predicted,
    // so the oldest expectation always belongs to the result on the ports.
    always @(posedge clk or negedge rst_n)
    begin : watch
        rsp_t want;
        if (!rst_n)
        begin
            head = '0;
            fill = '0;
            awaited_results.delete();
        end
        else
        begin
            if (done !== 1'b0)
            begin
                results_seen++;
                if (awaited_results.size() == 0)
                    report_mismatch("unrequested result, data_out", result.data_out, '0);
                else
                begin
                    want = awaited_results.pop_front();
                    if (result.data_out !== want.data_out)
                        report_mismatch("data_out", result.data_out, want.data_out);
                    if (result.status !== want.status)
                        report_mismatch("status", DATA_W'(result.status),
                                        DATA_W'(want.status));
                    if (result.length !== want.length)
                        report_mismatch("length", DATA_W'(result.length),
                                        DATA_W'(want.length));
                end
            end
            if (start === 1'b1 && busy === 1'b0)
                awaited_results.push_back(apply_request(request));
        end
        outstanding = awaited_results.size();
    end

endmodule

>>> test/tb_double_ended_queue.sv
`timescale 1ns / 1ps

// Stimulus and verdict for the double-ended queue. The checker instance beside the
// block predicts every result and counts mismatches; this module only feeds requests.
module tb_double_ended_queue;
    import dq_pkg::*;

    localparam int QDEPTH       = 16;
    localparam int RANDOM_ITEMS = 750;
    localparam int CYCLE_LIMIT  = 100000;

    // Function codes that the block must treat as no-ops.
    localparam logic [FUNC_W-1:0] FUNC_SPARE_LO = 3'd5;
    localparam logic [FUNC_W-1:0] FUNC_SPARE_HI = 3'd7;

    // Bias of a burst of random requests: toward filling, toward draining, or neither.
    typedef enum logic [1:0] {LEAN_FILL, LEAN_DRAIN, LEAN_MIXED} lean_t;

    logic clk     = 1'b0;
    logic rst_n   = 1'b0;
    logic start   = 1'b0;
    req_t request = '0;
    logic busy;
    logic done;
    rsp_t result;

    int errors;
    int outstanding;
    int cycle_count;

    // When set, the sender offers a new item on every cycle with no gaps.
    bit steady = 1'b0;

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    double_ended_queue #(
        .DEPTH(QDEPTH)
    ) dut (
        .clk(clk),
        .rst_n(rst_n),
        .start(start),
        .busy(busy),
        .request(request),
        .done(done),
        .result(result)
    );

    dq_checker #(
        .QDEPTH(QDEPTH)
    ) u_checker (
        .clk(clk),
        .rst_n(rst_n),
        .start(start),
        .busy(busy),
        .request(request),
        .done(done),
        .result(result),
        .errors(errors),
        .outstanding(outstanding)
    );

    // Data words lean on the extremes now and then, otherwise they are fully random.
    function automatic logic [DATA_W-1:0] pick_word();
        case ($urandom_range(7))
            0: return '0;
            1: return '1;
            default: return $urandom;
        endcase
    endfunction

    // Offers one item and holds it until the block takes it. Afterwards the sender
    // may go quiet unless steady is set; while quiet it scrambles the request bus so that
    // the block is seen to ignore it when start is low. Within this task the start line is
    // only lowered inside the quiet loop, never in the step where the next item raises it.
    task automatic issue(input logic [FUNC_W-1:0] func, input logic [DATA_W-1:0] word);
        req_t item;
        req_t junk;
        item.func    = func;
        item.data_in = word;
        start   <= 1'b1;
        request <= item;
        @(posedge clk);
        while (busy !== 1'b0)
            @(posedge clk);
        while (!steady && $urandom_range(99) < 36)
        begin
            junk.func    = FUNC_W'($urandom_range(7));
            junk.data_in = $urandom;
            start   <= 1'b0;
            request <= junk;
            @(posedge clk);
        end
    endtask

    // Watchdog: a run that never drains its expectations ends here as a failure.
    initial
    begin
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("double_ended_queue regression: fail");
        $finish;
    end

    initial
    begin
        lean_t             lean;
        int                burst;
        int                sent;
        int                roll;
        int                push_pct;
        logic [FUNC_W-1:0] op;

        repeat (4) @(posedge clk);
        rst_n <= 1'b1;

        // Directed part. Pops on the empty queue right after reset must be refused.
        issue(FUNC_POP_FRONT, '1);
        issue(FUNC_POP_BACK, '0);

        // The unused codes change nothing and report the current length.
        for (int code = FUNC_SPARE_LO; code <= FUNC_SPARE_HI; code++)
            issue(FUNC_W'(code), '1);

        // Fill the queue from both ends. The first push at the front moves the head
        // below zero, so the ring wraps early. Both data extremes go in first.
        for (int k = 0; k < QDEPTH; k++)
            issue((k % 2) ? FUNC_PUSH_FRONT : FUNC_PUSH_BACK,
                  (k == 0) ? '0 : (k == 1) ? '1 : $urandom);

        // The queue is full now, so both pushes are refused.
        issue(FUNC_PUSH_BACK, $urandom);
        issue(FUNC_PUSH_FRONT, $urandom);

        issue(FUNC_POP_FRONT, $urandom);
        issue(FUNC_POP_BACK, $urandom);

        // Clear empties the queue but keeps the storage; the pop after it is refused.
        issue(FUNC_CLEAR, $urandom);
        issue(FUNC_POP_BACK, $urandom);

        // Random part. Bursts that lean toward pushes or pops drive the queue to
        // full and back to empty often, so refusals and wrap-around are both common.
        // A window in the middle runs with no sender gaps at all.
        sent = 0;
        while (sent < RANDOM_ITEMS)
        begin
            lean  = lean_t'($urandom_range(2));
            burst = $urandom_range(50, 10);
            case (lean)
                LEAN_FILL:  push_pct = 80;
                LEAN_DRAIN: push_pct = 20;
                default:    push_pct = 50;
            endcase
            repeat (burst)
            begin
                steady = (sent >= 300 && sent < 420);
                roll   = $urandom_range(99);
                if (roll < 2)
                    op = FUNC_CLEAR;
                else if (roll < 5)
                    op = FUNC_W'($urandom_range(FUNC_SPARE_HI, FUNC_SPARE_LO));
                else if ($urandom_range(99) < push_pct)
                    op = $urandom_range(1) ? FUNC_PUSH_FRONT : FUNC_PUSH_BACK;
                else
                    op = $urandom_range(1) ? FUNC_POP_FRONT : FUNC_POP_BACK;
                issue(op, pick_word());
                // No-op codes do not count toward the item total.
                if (op < FUNC_SPARE_LO)
                    sent++;
            end
        end

        // Stop offering items and let every expected result come back. Outstanding
        // is read at the falling edge, after the checker has settled for the cycle.
        steady = 1'b0;
        start <= 1'b0;
        do
            @(negedge clk);
        while (outstanding != 0);

        // Waiting on past the last result catches any stray result strobe after it.
        repeat (4) @(posedge clk);
        @(negedge clk);

        if (errors == 0)
            $display("double_ended_queue regression: pass");
        else
            $display("double_ended_queue regression: fail");
        $finish;
    end

endmodule
